// ===== design/ffsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsc_pkg: shared types and constants of the frustum sphere cull block
// Widths of the fixed-point planes, the sphere item and the plane write bus.
// ----------------------------------------------------------------------------
package ffsc_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COORD_W  = 32;
  localparam int RAD_W    = 31;
  localparam int PLANE_W  = 32;
  localparam int N_PLANES = 6;
  localparam int N_COMPS  = 4;
  localparam int COMP_W   = $clog2(N_COMPS);
  localparam int PLANE_IDX_W = $clog2(N_PLANES);

  localparam int N_CFG     = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_SEL_W = $clog2(N_CFG);

  // Plane derivation widths
  localparam int RAW_W      = 33;              // sum of two Q16.16 entries
  localparam int SQ_W       = 2 * RAW_W;       // sum of three squares
  localparam int ROOT_W     = RAW_W;
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int DIV_W      = RAW_W + 1 + FRAC_BITS;  // rounded numerator
  localparam int DREM_W     = ROOT_W + 1;
  localparam int CNT_W      = $clog2(DIV_W + 1);

  // Sphere test widths
  localparam int PROD_W = 2 * COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int W_SHIFT = 16;

  localparam logic [CFG_W-1:0] CFG_RESET [N_CFG] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef enum logic [2:0] {
    GEN_IDLE,
    GEN_LOAD,
    GEN_SQR,
    GEN_ROOT,
    GEN_DIVLD,
    GEN_DIV,
    GEN_STORE
  } gen_state_e;

  // One plane component leaving the derivation unit
  typedef struct packed {
    logic                          we;
    logic [PLANE_IDX_W-1:0]        plane;
    logic [COMP_W-1:0]             comp;
    logic signed [PLANE_W-1:0]     value;
  } plane_wr_t;

  // Same write as seen by one cell
  typedef struct packed {
    logic                          we;
    logic [COMP_W-1:0]             comp;
    logic signed [PLANE_W-1:0]     value;
  } cell_wr_t;

  // Sphere item travelling along the chain
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          r;
    logic                      vis;
  } sphere_t;

endpackage

// ===== design/frustum_sphere_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_sphere_cull: view-frustum culling of bounding spheres
// Derives six clip planes from the configured matrix and tests one sphere
// per cycle against them in a chain of plane cells unless stalled or busy.
// ----------------------------------------------------------------------------
// A sphere item is taken every cycle unless the output stalls or the planes
// are being rebuilt; its visible flag leaves the last cell's second stage
// after six plane cells in a row, two register stages each (products, then
// sum and sign test). A stall on the output holds the whole chain. After
// reset and after every write of a matrix word the plane unit rebuilds all
// six planes: per plane a load step, the squaring of the normal and a
// bit-serial square root, then per component a bit-serial divider; in_ready_o
// stays low during that time. Writes at an index above seven are ignored.
module frustum_sphere_cull import ffsc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [COORD_W-1:0]  center_x_i,
  input  logic signed [COORD_W-1:0]  center_y_i,
  input  logic signed [COORD_W-1:0]  center_z_i,
  input  logic [RAD_W-1:0]           sphere_radius_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       visible_o
);

  logic      busy;
  plane_wr_t plane_wr;
  logic      pipe_en;

  logic    chain_valid [N_PLANES+1];
  sphere_t chain_item  [N_PLANES+1];
  logic [N_PLANES-1:0] valid_vec;

  ffsc_plane_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .wr_o        (plane_wr)
  );

  // The last cell's second stage is the output register
  assign pipe_en    = !out_valid_o || out_ready_i;
  // No item enters while planes are rebuilt or a matrix word lands
  assign in_ready_o = pipe_en && !busy && !cfg_we_i;

  assign chain_valid[0]    = in_valid_i && in_ready_o;
  assign chain_item[0].cx  = center_x_i;
  assign chain_item[0].cy  = center_y_i;
  assign chain_item[0].cz  = center_z_i;
  assign chain_item[0].r   = sphere_radius_i;
  assign chain_item[0].vis = 1'b1;

  for (genvar p = 0; p < N_PLANES; p++) begin : g_cell
    cell_wr_t cwr;
    assign cwr.we    = plane_wr.we && (plane_wr.plane == PLANE_IDX_W'(p));
    assign cwr.comp  = plane_wr.comp;
    assign cwr.value = plane_wr.value;
    assign valid_vec[p] = chain_valid[p+1];

    ffsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .wr_i    (cwr),
      .valid_i (chain_valid[p]),
      .item_i  (chain_item[p]),
      .valid_o (chain_valid[p+1]),
      .item_o  (chain_item[p+1])
    );
  end

  assign out_valid_o = chain_valid[N_PLANES];
  assign visible_o   = chain_item[N_PLANES].vis;

  // A matrix write always starts a plane rebuild
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_index_i < CFG_IDX_W'(N_CFG))) |=> busy)
    else $error("matrix write did not start plane rebuild");

  // Planes only change while no item can enter
  a_wr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plane_wr.we |-> !in_ready_o)
    else $error("plane written while input open");

  // A stalled chain keeps every item in place
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(valid_vec))
    else $error("chain moved during output stall");

endmodule

// ===== design/ffsc_plane_gen.sv =====
// ----------------------------------------------------------------------------
// ffsc_plane_gen: matrix registers and clip plane derivation
// Holds the eight matrix words and derives the six normalized planes one
// component at a time with a bit-serial square root and divider.
// ----------------------------------------------------------------------------
module ffsc_plane_gen import ffsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 busy_o,
  output plane_wr_t            wr_o
);

  logic [CFG_W-1:0] cfg_q [N_CFG];

  gen_state_e state_q, state_d;
  logic [PLANE_IDX_W-1:0] plane_q;
  logic [COMP_W-1:0]      comp_q;
  logic [CNT_W-1:0]       cnt_q;

  logic signed [RAW_W-1:0] raw_q [N_COMPS];
  logic [SQ_W-1:0]   prod_q, acc_q;
  logic              zero_q;
  logic [ROOT_W-1:0] root_q;
  logic [SREM_W-1:0] srem_q;
  logic [DIV_W-1:0]  dq_q;
  logic [DREM_W-1:0] drem_q;

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_index_i < CFG_IDX_W'(N_CFG));

  function automatic logic [RAW_W-1:0] mag(input logic signed [RAW_W-1:0] v);
    mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
  endfunction

  function automatic logic signed [RAW_W-1:0] half(input logic [CFG_W-1:0] w,
                                                   input logic hi);
    half = hi ? RAW_W'($signed(w[63:32])) : RAW_W'($signed(w[31:0]));
  endfunction

  // Raw plane components: row 3 plus or minus row k
  logic signed [RAW_W-1:0] raw_d [N_COMPS];
  always_comb begin
    logic [1:0] k;
    logic signed [RAW_W-1:0] e3, ek;
    k = plane_q[2:1];
    for (int j = 0; j < N_COMPS; j++) begin
      e3 = half(cfg_q[{2'd3, j[1]}], j[0]);
      ek = half(cfg_q[{k, j[1]}], j[0]);
      raw_d[j] = plane_q[0] ? e3 - ek : e3 + ek;
    end
  end

  // Square root step
  logic [SREM_W-1:0] s_sh, s_trial;
  logic              s_ge;
  assign s_sh    = {srem_q[SREM_W-3:0], acc_q[SQ_W-1 -: 2]};
  assign s_trial = SREM_W'({root_q, 2'b01});
  assign s_ge    = s_sh >= s_trial;

  // Divider step
  logic [DREM_W-1:0] d_sh, d_len;
  logic              d_ge;
  assign d_sh  = {drem_q[DREM_W-2:0], dq_q[DIV_W-1]};
  assign d_len = DREM_W'(root_q);
  assign d_ge  = d_sh >= d_len;

  logic [DIV_W-1:0] num_d;
  assign num_d = {1'b0, mag(raw_q[0]), {FRAC_BITS{1'b0}}} + DIV_W'(root_q[ROOT_W-1:1]);

  // Rounded quotient saturated into the plane word
  logic signed [PLANE_W-1:0] sat_val;
  always_comb begin
    if (raw_q[0][RAW_W-1]) begin
      if (dq_q > DIV_W'(33'h0_8000_0000)) sat_val = 32'sh8000_0000;
      else                                sat_val = PLANE_W'(-dq_q);
    end else begin
      if (dq_q > DIV_W'(33'h0_7FFF_FFFF)) sat_val = 32'sh7FFF_FFFF;
      else                                sat_val = PLANE_W'(dq_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      GEN_IDLE:  state_d = GEN_IDLE;
      GEN_LOAD:  state_d = GEN_SQR;
      GEN_SQR:   if (cnt_q == CNT_W'(N_COMPS - 1)) state_d = GEN_ROOT;
      GEN_ROOT:  if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = GEN_DIVLD;
      GEN_DIVLD: state_d = GEN_DIV;
      GEN_DIV:   if (cnt_q == CNT_W'(DIV_W - 1)) state_d = GEN_STORE;
      GEN_STORE: begin
        if (comp_q != COMP_W'(N_COMPS - 1))              state_d = GEN_DIVLD;
        else if (plane_q != PLANE_IDX_W'(N_PLANES - 1)) state_d = GEN_LOAD;
        else                                             state_d = GEN_IDLE;
      end
      default:   state_d = GEN_IDLE;
    endcase
    if (cfg_hit) state_d = GEN_LOAD;
  end

  // Outputs
  always_comb begin
    busy_o      = state_q != GEN_IDLE;
    wr_o.we     = state_q == GEN_STORE;
    wr_o.plane  = plane_q;
    wr_o.comp   = comp_q;
    wr_o.value  = zero_q ? '0 : sat_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GEN_LOAD;
      plane_q <= '0;
      comp_q  <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < N_CFG; i++) cfg_q[i] <= CFG_RESET[i];
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
      if (cfg_hit) cfg_q[cfg_index_i[CFG_SEL_W-1:0]] <= cfg_data_i;
      if (cfg_hit) begin
        plane_q <= '0;
        comp_q  <= '0;
      end else if (state_q == GEN_STORE) begin
        comp_q <= comp_q + COMP_W'(1);
        if (comp_q == COMP_W'(N_COMPS - 1)) begin
          plane_q <= (plane_q == PLANE_IDX_W'(N_PLANES - 1)) ? '0
                                                               : plane_q + PLANE_IDX_W'(1);
        end
      end
    end
  end

  // Datapath; raw words rotate so slot 0 is always the current component
  always_ff @(posedge clk_i) begin
    case (state_q)
      GEN_LOAD: begin
        for (int j = 0; j < N_COMPS; j++) raw_q[j] <= raw_d[j];
        acc_q  <= '0;
        prod_q <= '0;
        root_q <= '0;
        srem_q <= '0;
      end
      GEN_SQR: begin
        prod_q <= (cnt_q == CNT_W'(N_COMPS - 1)) ? '0
                  : SQ_W'(mag(raw_q[0])) * SQ_W'(mag(raw_q[0]));
        acc_q  <= acc_q + prod_q;
        zero_q <= (acc_q + prod_q) == '0;
        for (int j = 0; j < N_COMPS; j++) raw_q[j] <= raw_q[(j + 1) % N_COMPS];
      end
      GEN_ROOT: begin
        acc_q  <= {acc_q[SQ_W-3:0], 2'b00};
        srem_q <= s_ge ? s_sh - s_trial : s_sh;
        root_q <= {root_q[ROOT_W-2:0], s_ge};
      end
      GEN_DIVLD: begin
        dq_q   <= num_d;
        drem_q <= '0;
      end
      GEN_DIV: begin
        drem_q <= d_ge ? d_sh - d_len : d_sh;
        dq_q   <= {dq_q[DIV_W-2:0], d_ge};
      end
      GEN_STORE: begin
        for (int j = 0; j < N_COMPS; j++) raw_q[j] <= raw_q[(j + 1) % N_COMPS];
      end
      default: ;
    endcase
  end

endmodule

// ===== design/ffsc_cell.sv =====
// ----------------------------------------------------------------------------
// ffsc_cell: one clip plane and its two-stage sphere test
// Holds one plane, tests the passing sphere against it and hands it on.
// ----------------------------------------------------------------------------
module ffsc_cell import ffsc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  cell_wr_t wr_i,
  input  logic     valid_i,
  input  sphere_t  item_i,
  output logic     valid_o,
  output sphere_t  item_o
);

  logic signed [PLANE_W-1:0] plane_q [N_COMPS];

  logic                     a_valid_q, b_valid_q;
  sphere_t                  a_item_q, b_item_q;
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;
  logic signed [SUM_W-1:0]  base_q;

  logic signed [SUM_W-1:0] base_d, sum_d;
  sphere_t                 b_item_d;

  // w scaled to the product fraction, plus the radius
  assign base_d = (SUM_W'(plane_q[3]) <<< W_SHIFT) +
                  $signed({{(SUM_W - RAD_W - FRAC_BITS){1'b0}}, item_i.r,
                           {FRAC_BITS{1'b0}}});

  assign sum_d = SUM_W'(px_q) + SUM_W'(py_q) + SUM_W'(pz_q) + base_q;

  // this plane's verdict joins the running flag
  always_comb begin
    b_item_d     = a_item_q;
    b_item_d.vis = a_item_q.vis & ~sum_d[SUM_W-1];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) plane_q[wr_i.comp] <= wr_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_item_q <= item_i;
      px_q     <= PROD_W'(plane_q[0]) * PROD_W'(item_i.cx);
      py_q     <= PROD_W'(plane_q[1]) * PROD_W'(item_i.cy);
      pz_q     <= PROD_W'(plane_q[2]) * PROD_W'(item_i.cz);
      base_q   <= base_d;
      b_item_q <= b_item_d;
    end
  end

  assign valid_o = b_valid_q;
  assign item_o  = b_item_q;

endmodule

// ===== verif/tb_frustum_sphere_cull.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frustum_sphere_cull: self-checking bench for the frustum sphere cull
// A bit-exact plane builder and sphere test give the expected visible flag
// for every accepted sphere. Matrix sets run from identity to the extremes.
// Both handshakes idle at random, and one long output stall backs up the chain.
// ----------------------------------------------------------------------------
module tb_frustum_sphere_cull;
  import ffsc_pkg::*;

  // Matrix word indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO  = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI  = 4'd15;

  localparam int ONE = 65536;  // 1.0 in Q16.16

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [RAD_W-1:0]          r;
  } ball_t;

  // --------------------------------------------------------------------------
  // Plane builder and sphere predictor, plus the queue of expected flags
  // --------------------------------------------------------------------------
  class cull_scoreboard;
    logic [CFG_W-1:0]          mat_words[N_CFG];
    logic signed [PLANE_W-1:0] planes[N_PLANES][N_COMPS];
    bit                        vis_q[$];
    int                        errs;

    function new();
      foreach (mat_words[i]) mat_words[i] = CFG_RESET[i];
      errs = 0;
      build_planes();
    endfunction

    function longint entry(int row, int col);
      logic [CFG_W-1:0] w;
      w = mat_words[row * 2 + col / 2];
      return (col % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
    endfunction

    // floor(sqrt) of a 66-bit value, two bits per step
    function logic [63:0] root66(logic [65:0] v);
      logic [67:0] rem, trial, rt;
      rem = 0;
      rt = 0;
      for (int i = 32; i >= 0; i--) begin
        rem = (rem << 2) | v[2*i +: 2];
        trial = (rt << 2) | 1;
        if (rem >= trial) begin
          rem -= trial;
          rt = (rt << 1) | 1;
        end else begin
          rt = rt << 1;
        end
      end
      return rt[63:0];
    endfunction

    function void build_planes();
      longint      raw[N_COMPS];
      logic [65:0] sumsq, m;
      logic [63:0] len, q, mg;
      for (int p = 0; p < N_PLANES; p++) begin
        sumsq = 0;
        for (int j = 0; j < N_COMPS; j++)
          raw[j] = (p % 2) ? entry(3, j) - entry(p / 2, j) : entry(3, j) + entry(p / 2, j);
        for (int j = 0; j < 3; j++) begin
          m = (raw[j] < 0) ? 66'(-raw[j]) : 66'(raw[j]);
          sumsq += m * m;
        end
        if (sumsq == 0) begin
          // degenerate normal: plane never rejects
          for (int j = 0; j < N_COMPS; j++) planes[p][j] = 0;
        end else begin
          len = root66(sumsq);
          for (int j = 0; j < N_COMPS; j++) begin
            mg = (raw[j] < 0) ? 64'(-raw[j]) : 64'(raw[j]);
            q = ((mg << FRAC_BITS) + (len >> 1)) / len;
            if (raw[j] < 0) begin
              if (q > 64'h8000_0000) q = 64'h8000_0000;
              planes[p][j] = -q[31:0];
            end else begin
              if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
              planes[p][j] = q[31:0];
            end
          end
        end
      end
    endfunction

    function void write_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx < N_CFG) begin
        mat_words[idx] = data;
        build_planes();
      end
    endfunction

    function void note_sphere(ball_t b);
      logic signed [69:0] s, n0, n1, n2, w, x, y, z, r;
      bit vis;
      vis = 1;
      x = b.cx;
      y = b.cy;
      z = b.cz;
      r = $signed({1'b0, b.r});
      for (int p = 0; p < N_PLANES; p++) begin
        n0 = planes[p][0];
        n1 = planes[p][1];
        n2 = planes[p][2];
        w  = planes[p][3];
        s = n0 * x + n1 * y + n2 * z + (w <<< W_SHIFT) + (r <<< FRAC_BITS);
        if (s < 0) vis = 0;
      end
      vis_q = {vis_q, vis};
    endfunction

    function void check_visible(logic got);
      bit exp_vis;
      if (vis_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result: visible=%0b", got);
        return;
      end
      exp_vis = vis_q.pop_front();
      if (got !== exp_vis) begin
        errs++;
        if (errs <= 10) $display("visible mismatch: expected %0b got %0b", exp_vis, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_W-1:0]          cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] center_x_i = '0;
  logic signed [COORD_W-1:0] center_y_i = '0;
  logic signed [COORD_W-1:0] center_z_i = '0;
  logic [RAD_W-1:0]          sphere_radius_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      visible_o;

  cull_scoreboard sb;
  bit             calm_mode = 0;  // no idling on either side while set
  bit             hold_req = 0;   // asks the receiver for one long stall
  bit             stim_done = 0;

  frustum_sphere_cull i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .center_x_i, .center_y_i, .center_z_i,
    .sphere_radius_i, .out_valid_o, .out_ready_i, .visible_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // hard stop; slowest legal run is well under a tenth of this
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function int draw_gap();
    return calm_mode ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (hold_req) begin
        hold_req = 0;
        gap = 400;  // long enough to back up the whole chain
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_visible(visible_o);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  task automatic send_sphere(ball_t b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    center_x_i      <= b.cx;
    center_y_i      <= b.cy;
    center_z_i      <= b.cz;
    sphere_radius_i <= b.r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sphere(b);
  endtask

  task automatic send_ball(int x, int y, int z, int r);
    ball_t b;
    b.cx = x;
    b.cy = y;
    b.cz = z;
    b.r = r[RAD_W-1:0];
    send_sphere(b);
  endtask

  // Mostly spheres near the frustum, where the answer depends on the planes
  function automatic ball_t rand_ball();
    ball_t b;
    int    span;
    if ($urandom_range(0, 9) < 3) begin
      b.cx = $urandom;
      b.cy = $urandom;
      b.cz = $urandom;
      b.r = RAD_W'($urandom);
    end else begin
      span = 1 << $urandom_range(14, 20);
      b.cx = $urandom_range(0, 2 * span) - span;
      b.cy = $urandom_range(0, 2 * span) - span;
      b.cz = $urandom_range(0, 2 * span) - span;
      b.r = ($urandom_range(0, 3) == 0) ? '0 : RAD_W'($urandom_range(0, span));
    end
    return b;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_sphere(rand_ball());
  endtask

  // Matrix writes only with nothing in flight
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.vis_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // one write, then write enable low again before returning
  task automatic write_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_word(idx, data);
    @(posedge clk_i);
  endtask

  // entries given row by row, column 0 first
  task automatic load_matrix(int m[16]);
    write_word(REG_ROW0_C01, {m[1], m[0]});
    write_word(REG_ROW0_C23, {m[3], m[2]});
    write_word(REG_ROW1_C01, {m[5], m[4]});
    write_word(REG_ROW1_C23, {m[7], m[6]});
    write_word(REG_ROW2_C01, {m[9], m[8]});
    write_word(REG_ROW2_C23, {m[11], m[10]});
    write_word(REG_ROW3_C01, {m[13], m[12]});
    write_word(REG_ROW3_C23, {m[15], m[14]});
  endtask

  // entries within +-4.0, like a typical view-projection
  task automatic load_camera_like();
    int m[16];
    foreach (m[i]) m[i] = $urandom_range(0, 8 * ONE) - 4 * ONE;
    load_matrix(m);
  endtask

  task automatic load_fill(int v);
    int m[16];
    foreach (m[i]) m[i] = v;
    load_matrix(m);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int m[16];
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity planes: the unit cube around the origin
    send_ball(0, 0, 0, 0);
    send_ball(ONE, 0, 0, 0);            // exactly on a face: kept
    send_ball(ONE + 1, 0, 0, 0);        // one step outside: culled
    send_ball(ONE + 1, 0, 0, 1);        // radius reaches back in
    send_ball(0, -ONE - 1, 0, 0);
    send_ball(0, 0, 3 * ONE, 2 * ONE);
    send_ball(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ball(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_ball(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_ball(32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
    send_ball(-1, -1, -1, 0);
    send_random(140);

    // writes to missing registers leave the matrix alone
    wait_drained();
    write_word(REG_NONE_LO, '1);
    write_word(REG_NONE_HI, 64'h8000_0000_8000_0000);
    send_random(60);

    // camera-like matrix
    wait_drained();
    load_camera_like();
    send_random(150);

    // planes 0 and 1 degenerate (row 3 equal to row 0), the rest normal
    wait_drained();
    foreach (m[i]) m[i] = $urandom_range(0, 8 * ONE) - 4 * ONE;
    for (int j = 0; j < 4; j++) m[12 + j] = m[j];
    m[12] = 0; m[13] = 0; m[14] = 0;
    m[0] = 0; m[1] = 0; m[2] = 0;
    load_matrix(m);
    send_ball(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_random(140);

    // tiny normals with a huge offset: w saturates
    wait_drained();
    foreach (m[i]) m[i] = 0;
    m[0] = 1; m[5] = -1; m[10] = 1; m[15] = 32'h7FFF_FFFF;
    load_matrix(m);
    send_ball(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_random(140);

    // long receiver stall while the sender keeps offering
    wait_drained();
    load_camera_like();
    calm_mode = 1;
    hold_req = 1;
    send_random(150);
    calm_mode = 0;

    // extremes of every entry
    wait_drained();
    load_fill(32'h7FFF_FFFF);
    send_random(100);
    wait_drained();
    load_fill(32'h8000_0000);
    send_random(100);
    wait_drained();
    load_fill(0);                       // all planes degenerate
    send_random(60);

    // fully random words
    wait_drained();
    for (int i = 0; i < N_CFG; i++) write_word(i[CFG_IDX_W-1:0], {$urandom, $urandom});
    send_random(120);

    wait_drained();
    load_camera_like();
    send_random(150);

    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // --------------------------------------------------------------------------
  // End of run
  // --------------------------------------------------------------------------
  initial begin
    wait (stim_done);
    while (sb.vis_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errs == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/ffsc_pkg.sv
design/ffsc_plane_gen.sv
design/ffsc_cell.sv
design/frustum_sphere_cull.sv
verif/tb_frustum_sphere_cull.sv
